/* hw/rtl/grf_mixed_des_block_decoder_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the mixed DES block decoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef GRF_MIXED_DES_BLOCK_DECODER_ASSERT_SVH
`define GRF_MIXED_DES_BLOCK_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MDBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mdbd: assertion failed");
// Condition that must never be seen outside reset.
`define MDBD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `MDBD_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define MDBD_ASSERT(lbl, clk, rst_n, prop)
`define MDBD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/mdbd_pkg.sv */
// ---------------------------------------------------------------------------
// Mixed DES block decoder package
// Shared types, register indexes, cipher tables and permutation functions.
// ---------------------------------------------------------------------------
`default_nettype none

package mdbd_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned CountW = 5;
  localparam int unsigned ShufW  = 3;

  // Register indexes on the configuration port.
  localparam logic CfgKeyCycle = 1'b0;
  localparam logic CfgNameMode = 1'b1;

  localparam logic [CountW-1:0] EarlyBlocks = 5'd20;
  localparam logic [ShufW-1:0]  ShufLast    = 3'd7;

  // Treatment chosen for one block.
  typedef struct packed {
    logic nib_swap;
    logic do_core;
    logic do_shuffle;
  } op_t;

  localparam logic [7:0] IP_TAB [64] = '{
    8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
    8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
  };

  localparam logic [7:0] FP_TAB [64] = '{
    8'd40, 8'd8,  8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
    8'd39, 8'd7,  8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
    8'd38, 8'd6,  8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
    8'd37, 8'd5,  8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
    8'd36, 8'd4,  8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
    8'd35, 8'd3,  8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
    8'd34, 8'd2,  8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
    8'd33, 8'd1,  8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25
  };

  localparam logic [7:0] P_TAB [32] = '{
    8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
    8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
    8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
    8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25
  };

  localparam logic [7:0] SBOX [4][64] = '{
    '{8'hef,8'h03,8'h41,8'hfd,8'hd8,8'h74,8'h1e,8'h47,8'h26,8'hef,8'hfb,8'h22,8'hb3,8'hd8,8'h84,8'h1e,
      8'h39,8'hac,8'ha7,8'h60,8'h62,8'hc1,8'hcd,8'hba,8'h5c,8'h96,8'h90,8'h59,8'h05,8'h3b,8'h7a,8'h85,
      8'h40,8'hfd,8'h1e,8'hc8,8'he7,8'h8a,8'h8b,8'h21,8'hda,8'h43,8'h64,8'h9f,8'h2d,8'h14,8'hb1,8'h72,
      8'hf5,8'h5b,8'hc8,8'hb6,8'h9c,8'h37,8'h76,8'hec,8'h39,8'ha0,8'ha3,8'h05,8'h52,8'h6e,8'h0f,8'hd9},
    '{8'ha7,8'hdd,8'h0d,8'h78,8'h9e,8'h0b,8'he3,8'h95,8'h60,8'h36,8'h36,8'h4f,8'hf9,8'h60,8'h5a,8'ha3,
      8'h11,8'h24,8'hd2,8'h87,8'hc8,8'h52,8'h75,8'hec,8'hbb,8'hc1,8'h4c,8'hba,8'h24,8'hfe,8'h8f,8'h19,
      8'hda,8'h13,8'h66,8'haf,8'h49,8'hd0,8'h90,8'h06,8'h8c,8'h6a,8'hfb,8'h91,8'h37,8'h8d,8'h0d,8'h78,
      8'hbf,8'h49,8'h11,8'hf4,8'h23,8'he5,8'hce,8'h3b,8'h55,8'hbc,8'ha2,8'h57,8'he8,8'h22,8'h74,8'hce},
    '{8'h2c,8'hea,8'hc1,8'hbf,8'h4a,8'h24,8'h1f,8'hc2,8'h79,8'h47,8'ha2,8'h7c,8'hb6,8'hd9,8'h68,8'h15,
      8'h80,8'h56,8'h5d,8'h01,8'h33,8'hfd,8'hf4,8'hae,8'hde,8'h30,8'h07,8'h9b,8'he5,8'h83,8'h9b,8'h68,
      8'h49,8'hb4,8'h2e,8'h83,8'h1f,8'hc2,8'hb5,8'h7c,8'ha2,8'h19,8'hd8,8'he5,8'h7c,8'h2f,8'h83,8'hda,
      8'hf7,8'h6b,8'h90,8'hfe,8'hc4,8'h01,8'h5a,8'h97,8'h61,8'ha6,8'h3d,8'h40,8'h0b,8'h58,8'he6,8'h3d},
    '{8'h4d,8'hd1,8'hb2,8'h0f,8'h28,8'hbd,8'he4,8'h78,8'hf6,8'h4a,8'h0f,8'h93,8'h8b,8'h17,8'hd1,8'ha4,
      8'h3a,8'hec,8'hc9,8'h35,8'h93,8'h56,8'h7e,8'hcb,8'h55,8'h20,8'ha0,8'hfe,8'h6c,8'h89,8'h17,8'h62,
      8'h17,8'h62,8'h4b,8'hb1,8'hb4,8'hde,8'hd1,8'h87,8'hc9,8'h14,8'h3c,8'h4a,8'h7e,8'ha8,8'he2,8'h7d,
      8'ha0,8'h9f,8'hf6,8'h5c,8'h6a,8'h09,8'h8d,8'hf0,8'h0f,8'he3,8'h53,8'h25,8'h95,8'h36,8'h28,8'hcb}
  };

  // Result bit i is source bit tab[i]-1, both counted from the top.
  function automatic logic [63:0] permute64(input logic [63:0] w,
                                            input logic [7:0] tab [64]);
    logic [63:0] r;
    logic [5:0]  src;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      src = 6'(tab[i] - 8'd1);
      r[63-i] = w[6'd63 - src];
    end
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r);
    logic [7:0]  b4, b5, b6, b7;
    logic [5:0]  e [8];
    logic [31:0] s;
    logic [31:0] p;
    logic [4:0]  src;
    b4 = r[31:24];
    b5 = r[23:16];
    b6 = r[15:8];
    b7 = r[7:0];
    e[0] = {b7[0], b4[7:3]};
    e[1] = {b4[4:0], b5[7]};
    e[2] = {b4[0], b5[7:3]};
    e[3] = {b5[4:0], b6[7]};
    e[4] = {b5[0], b6[7:3]};
    e[5] = {b6[4:0], b7[7]};
    e[6] = {b6[0], b7[7:3]};
    e[7] = {b7[4:0], b4[7]};
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s[31-8*i -: 8] = {SBOX[i][e[2*i]][7:4], SBOX[i][e[2*i+1]][3:0]};
    end
    p = '0;
    for (int i = 0; i < 32; i++) begin
      src = 5'(P_TAB[i] - 8'd1);
      p[31-i] = s[5'd31 - src];
    end
    return p;
  endfunction

  function automatic logic [63:0] des_core(input logic [63:0] w);
    logic [63:0] ip;
    logic [31:0] l;
    ip = permute64(w, IP_TAB);
    l  = ip[63:32] ^ feistel(ip[31:0]);
    return permute64({l, ip[31:0]}, FP_TAB);
  endfunction

  // Seven byte pairs trade places; every other value passes unchanged.
  function automatic logic [7:0] swap_byte(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00:   r = 8'h2b;
      8'h2b:   r = 8'h00;
      8'h01:   r = 8'h68;
      8'h68:   r = 8'h01;
      8'h48:   r = 8'h77;
      8'h77:   r = 8'h48;
      8'h60:   r = 8'hff;
      8'hff:   r = 8'h60;
      8'h6c:   r = 8'h80;
      8'h80:   r = 8'h6c;
      8'hb9:   r = 8'hc0;
      8'hc0:   r = 8'hb9;
      8'heb:   r = 8'hfe;
      8'hfe:   r = 8'heb;
      default: r = a;
    endcase
    return r;
  endfunction

  function automatic logic [CountW-1:0] derived_period(input logic [3:0] c);
    logic [CountW-1:0] cx;
    logic [CountW-1:0] r;
    cx = {1'b0, c};
    if (c < 4'd3) begin
      r = 5'd3;
    end else if (c < 4'd5) begin
      r = cx + 5'd1;
    end else if (c < 4'd7) begin
      r = cx + 5'd9;
    end else begin
      r = cx + 5'd15;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mdbd_intf.sv */
// ---------------------------------------------------------------------------
// Mixed DES block decoder stream interfaces
// Valid/ready channels for cipher blocks in and plain blocks out.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdbd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_block;
  logic        first_block;

  modport source (output valid, output cipher_block, output first_block, input ready);
  modport sink   (input valid, input cipher_block, input first_block, output ready);
endinterface

interface mdbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink   (input valid, input plain_block, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mdbd_ctrl.sv */
// ---------------------------------------------------------------------------
// Mixed DES block decoder control
// Configuration registers and block counters; picks the treatment per beat.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grf_mixed_des_block_decoder_assert.svh"

module mdbd_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        fire_i,
  input  wire logic        first_i,
  output mdbd_pkg::op_t    op_o
);
  import mdbd_pkg::*;

  logic [3:0]        key_cycle_q;
  logic              name_mode_q;
  logic [CountW-1:0] early_q, early_d;
  logic [CountW-1:0] phase_q, phase_d;
  logic [ShufW-1:0]  shuf_q, shuf_d;

  logic [CountW-1:0] early_c, phase_c, period;
  logic [ShufW-1:0]  shuf_c;
  logic [CountW:0]   phase_inc;
  logic              only_early;
  op_t               op;

  always_comb begin
    early_c    = first_i ? '0 : early_q;
    phase_c    = first_i ? '0 : phase_q;
    shuf_c     = first_i ? '0 : shuf_q;
    only_early = (key_cycle_q == 4'd0);
    period     = derived_period(key_cycle_q);
    phase_inc  = {1'b0, phase_c} + 6'd1;

    op = '0;
    early_d = early_q;
    phase_d = phase_q;
    shuf_d  = shuf_q;
    if (name_mode_q) begin
      op.nib_swap = 1'b1;
      op.do_core  = 1'b1;
    end else begin
      op.do_core = (early_c < EarlyBlocks) || (!only_early && phase_c == '0);
      shuf_d = shuf_c;
      if (!op.do_core) begin
        op.do_shuffle = (shuf_c == ShufLast) && !only_early;
        // A shuffle restarts the gap count, so the next gap is one shorter.
        shuf_d = op.do_shuffle ? ShufW'(1) : shuf_c + ShufW'(1);
      end
      early_d = (early_c < EarlyBlocks) ? early_c + CountW'(1) : EarlyBlocks;
      phase_d = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[CountW-1:0];
    end
  end

  assign op_o = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cycle_q <= '0;
      name_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyCycle: key_cycle_q <= cfg_wdata_i;
        CfgNameMode: name_mode_q <= cfg_wdata_i[0];
        default:     key_cycle_q <= key_cycle_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= '0;
      phase_q <= '0;
      shuf_q  <= '0;
    end else if (fire_i) begin
      early_q <= early_d;
      phase_q <= phase_d;
      shuf_q  <= shuf_d;
    end
  end

  `MDBD_ASSERT(a_early_sat, clk_i, rst_ni, early_q <= EarlyBlocks)
  `MDBD_ASSERT(a_shuf_restart, clk_i, rst_ni, fire_i && op.do_shuffle |=> shuf_q == ShufW'(1))
  `MDBD_ASSERT_NEVER(a_core_xor_shuf, clk_i, rst_ni, op.do_core && op.do_shuffle)

endmodule

`default_nettype wire

/* hw/rtl/mdbd_datapath.sv */
// ---------------------------------------------------------------------------
// Mixed DES block decoder datapath
// Nibble swap, one-round DES-like core and byte shuffle for one block.
// ---------------------------------------------------------------------------
`default_nettype none

module mdbd_datapath (
  input  wire logic [63:0] block_i,
  input  mdbd_pkg::op_t    op_i,
  output logic [63:0]      block_o
);
  import mdbd_pkg::*;

  logic [63:0] swapped;
  logic [63:0] shuffled;

  always_comb begin
    swapped = block_i;
    if (op_i.nib_swap) begin
      for (int i = 0; i < 8; i++) begin
        swapped[8*i +: 8] = {block_i[8*i +: 4], block_i[8*i+4 +: 4]};
      end
    end
  end

  // Output bytes 0..6 take input bytes 3,4,6,0,1,2,5; byte 7 goes through the swap table.
  assign shuffled = {block_i[39:32], block_i[31:24], block_i[15:8], block_i[63:56],
                     block_i[55:48], block_i[47:40], block_i[23:16],
                     swap_byte(block_i[7:0])};

  always_comb begin
    if (op_i.do_core) begin
      block_o = des_core(swapped);
    end else if (op_i.do_shuffle) begin
      block_o = shuffled;
    end else begin
      block_o = block_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/grf_mixed_des_block_decoder.sv */
// ---------------------------------------------------------------------------
// Mixed DES block decoder
// Decodes one 8-byte archive block per beat with a keyless DES-like core.
// ---------------------------------------------------------------------------
// The decoder takes one beat per clock cycle unless the output stalls it.
// The input stage registers each accepted block with its treatment, chosen
// as the block counters advance; the datapath then feeds the result
// register. Both stages are plain registers with a valid bit, so a new beat
// can be accepted while a finished block still waits on the output if the
// input stage is empty. In data mode the first twenty blocks of a file pass
// through the core; if key_cycle is nonzero, later blocks go through the
// core when their index is a multiple of the period derived from key_cycle,
// and of the rest every eighth, then every seventh, is byte-shuffled. In
// name mode every block is nibble-swapped and then passed through the core.
// Registers must only be written while no beat is in flight.
`default_nettype none
`include "grf_mixed_des_block_decoder_assert.svh"

module grf_mixed_des_block_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_wdata_i,
  mdbd_in_if.sink          in_bus,
  mdbd_out_if.source       out_bus
);
  import mdbd_pkg::*;

  // Input stage: the raw block and the treatment chosen on acceptance.
  logic              s1_vld_q, s1_vld_d;
  logic [BlockW-1:0] s1_blk_q;
  op_t               s1_op_q;

  // Result register.
  logic              out_vld_q, out_vld_d;
  logic [BlockW-1:0] out_blk_q;

  logic              s1_adv;
  logic              in_fire;
  op_t               op_sel;
  logic [BlockW-1:0] dp_blk;

  // The input stage moves on whenever the result register is free or drained.
  assign s1_adv       = !out_vld_q || out_bus.ready;
  assign in_bus.ready = !s1_vld_q || s1_adv;
  assign in_fire      = in_bus.valid && in_bus.ready;

  mdbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire),
    .first_i     (in_bus.first_block),
    .op_o        (op_sel)
  );

  mdbd_datapath u_datapath (
    .block_i (s1_blk_q),
    .op_i    (s1_op_q),
    .block_o (dp_blk)
  );

  always_comb begin
    s1_vld_d  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_q);
    out_vld_d = s1_adv ? s1_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_blk_q <= in_bus.cipher_block;
      s1_op_q  <= op_sel;
    end
    if (s1_adv && s1_vld_q) begin
      out_blk_q <= dp_blk;
    end
  end

  assign out_bus.valid       = out_vld_q;
  assign out_bus.plain_block = out_blk_q;

  `MDBD_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_vld_q |-> in_bus.ready)
  `MDBD_ASSERT(a_s1_held, clk_i, rst_ni, s1_vld_q && !s1_adv |=> s1_vld_q)
  `MDBD_ASSERT(a_out_drain, clk_i, rst_ni, out_vld_q && out_bus.ready && !s1_vld_q |=> !out_vld_q)

endmodule

`default_nettype wire
